>>> rtl/cdda_pkg.sv
// types, constants and calendar helpers for the date day adder
package cdda_pkg;

   localparam int DayBits   = 5;
   localparam int MonthBits = 4;
   localparam int YearBits  = 14;
   localparam int ActBits   = 2;
   localparam int CountBits = 16;
   localparam int ModBits   = 9;

   localparam logic [YearBits-1:0]  MaxYear     = 14'd9999;
   localparam logic [YearBits-1:0]  BaseYear    = 14'd1900;
   localparam logic [ModBits-1:0]   BaseYearMod = 9'd300;
   localparam logic [YearBits-1:0]  Cycle400    = 14'd400;
   localparam logic [ModBits-1:0]   LastMod     = 9'd399;
   localparam logic [MonthBits-1:0] MonthJan    = 4'd1;
   localparam logic [MonthBits-1:0] MonthFeb    = 4'd2;
   localparam logic [MonthBits-1:0] MonthDec    = 4'd12;
   localparam logic [DayBits-1:0]   DayFirst    = 5'd1;

   typedef enum logic [ActBits-1:0] {
      ACT_LOAD = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_SUB  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // leap test from year mod 400
   function automatic logic is_leap(input logic [ModBits-1:0] m400);
      is_leap = (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200)
                && (m400 != 9'd300);
   endfunction

   // days in month, zero for a month code outside 1 to 12
   function automatic logic [DayBits-1:0] month_len(input logic [MonthBits-1:0] m,
                                                   input logic leap);
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
         4'd2:                                      month_len = leap ? 5'd29 : 5'd28;
         default:                                   month_len = 5'd0;
      endcase
   endfunction

endpackage

>>> rtl/cdda_if.sv
// request and response channel interfaces of the date day adder
interface cdda_req_if;
   import cdda_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ActBits-1:0]   action;
   logic [DayBits-1:0]   load_day;
   logic [MonthBits-1:0] load_month;
   logic [YearBits-1:0]  load_year;
   logic [CountBits-1:0] day_count;
   modport source (output valid, action, load_day, load_month, load_year, day_count,
                   input ready);
   modport sink   (input valid, action, load_day, load_month, load_year, day_count,
                   output ready);
endinterface

interface cdda_rsp_if;
   import cdda_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [DayBits-1:0]   out_day;
   logic [MonthBits-1:0] out_month;
   logic [YearBits-1:0]  out_year;
   logic                 error;
   modport source (output valid, out_day, out_month, out_year, error, input ready);
   modport sink   (input valid, out_day, out_month, out_year, error, output ready);
endinterface

>>> rtl/calendar_date_day_adder_unit.sv
// gregorian date register with load, add days and subtract days
//
// req_chan takes one item: an action (load, add, subtract) with a load date
// and a day count. rsp_chan returns one item per request: the date after the
// step and an error flag. A rejected load or a year leaving 0 to 9999 keeps
// the old date and flags error.
// One item at a time: req_chan.ready is high only while the sequencer idles.
// Add and subtract walk one month per cycle through a single month-length
// subtract/compare unit. A load first reduces the year mod 400 by repeated
// subtraction of 400 for the leap test.
// A new item may be accepted while a response waits; if that item finishes
// before the response is taken, the sequencer holds until rsp_chan.ready.
// Synchronous reset sets the date to 1/1/1900 and drops rsp_chan.valid.
module calendar_date_day_adder_unit #(
   parameter int COUNT_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   cdda_req_if.sink   req_chan,
   cdda_rsp_if.source rsp_chan
);
   import cdda_pkg::*;

   localparam int UseBits = (COUNT_BITS < CountBits) ? COUNT_BITS : CountBits;
   localparam int DW      = UseBits + 7;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic signed [DW-1:0]   wd_ff, wd_in;
   logic [MonthBits-1:0]   wm_ff, wm_in;
   logic [YearBits-1:0]    wy_ff, wy_in;
   logic [ModBits-1:0]     wm400_ff, wm400_in;
   logic [YearBits-1:0]    wrem_ff, wrem_in;
   logic [DayBits-1:0]     ld_day_ff, ld_day_in;
   logic                   werr_ff, werr_in;
   logic [DayBits-1:0]     cur_day_ff, cur_day_in;
   logic [MonthBits-1:0]   cur_month_ff, cur_month_in;
   logic [YearBits-1:0]    cur_year_ff, cur_year_in;
   logic [ModBits-1:0]     cur_m400_ff, cur_m400_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DayBits-1:0]     rsp_day_ff, rsp_day_in;
   logic [MonthBits-1:0]   rsp_month_ff, rsp_month_in;
   logic [YearBits-1:0]    rsp_year_ff, rsp_year_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic [UseBits-1:0]     cnt;
   logic signed [DW-1:0]   cur_day_s, cnt_s;
   logic [DayBits-1:0]     len_cur, len_prev, len_load;
   logic signed [DW-1:0]   len_cur_s, len_prev_s;
   logic                   wrap_dn;
   logic [MonthBits-1:0]   prev_m;
   logic [ModBits-1:0]     prev_m400, dec_m400, inc_m400;
   logic                   load_bad;

   assign cnt       = req_chan.day_count[UseBits-1:0];
   assign cur_day_s = signed'(DW'(cur_day_ff));
   assign cnt_s     = signed'(DW'(cnt));

   // shared month-length unit
   assign inc_m400   = (wm400_ff == LastMod) ? '0 : wm400_ff + 9'd1;
   assign dec_m400   = (wm400_ff == '0) ? LastMod : wm400_ff - 9'd1;
   assign wrap_dn    = (wm_ff <= MonthJan);
   assign prev_m     = wrap_dn ? MonthDec : wm_ff - 4'd1;
   assign prev_m400  = wrap_dn ? dec_m400 : wm400_ff;
   assign len_cur    = month_len(wm_ff, is_leap(wm400_ff));
   assign len_prev   = month_len(prev_m, is_leap(prev_m400));
   assign len_cur_s  = signed'(DW'(len_cur));
   assign len_prev_s = signed'(DW'(len_prev));
   assign len_load   = month_len(wm_ff, is_leap(wrem_ff[ModBits-1:0]));
   assign load_bad   = (wy_ff > MaxYear) || (len_load == '0) || (ld_day_ff == '0)
                       || (ld_day_ff > len_load);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      wd_in        = wd_ff;
      wm_in        = wm_ff;
      wy_in        = wy_ff;
      wm400_in     = wm400_ff;
      wrem_in      = wrem_ff;
      ld_day_in    = ld_day_ff;
      werr_in      = werr_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      cur_m400_in  = cur_m400_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               act_in    = action_type'(req_chan.action);
               ld_day_in = req_chan.load_day;
               werr_in   = 1'b0;
               wm400_in  = cur_m400_ff;
               case (action_type'(req_chan.action))
                  ACT_LOAD: begin
                     wm_in    = req_chan.load_month;
                     wy_in    = req_chan.load_year;
                     wrem_in  = req_chan.load_year;
                     state_in = ST_LOAD;
                  end
                  ACT_ADD: begin
                     wd_in    = cur_day_s + cnt_s;
                     wm_in    = cur_month_ff;
                     wy_in    = cur_year_ff;
                     state_in = ST_WALK;
                  end
                  ACT_SUB: begin
                     wd_in    = cur_day_s - cnt_s;
                     wm_in    = cur_month_ff;
                     wy_in    = cur_year_ff;
                     state_in = ST_WALK;
                  end
                  default: begin
                     werr_in  = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (wrem_ff >= Cycle400) begin
               wrem_in = wrem_ff - Cycle400;
            end else begin
               werr_in  = load_bad;
               state_in = ST_DONE;
               if (!load_bad) begin
                  cur_day_in   = ld_day_ff;
                  cur_month_in = wm_ff;
                  cur_year_in  = wy_ff;
                  cur_m400_in  = wrem_ff[ModBits-1:0];
               end
            end
         end
         ST_WALK: begin
            if (act_ff == ACT_ADD && wd_ff > len_cur_s) begin
               wd_in = wd_ff - len_cur_s;
               if (wm_ff == MonthDec) begin
                  wm_in = MonthJan;
                  if (wy_ff == MaxYear) begin
                     werr_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     wy_in    = wy_ff + 14'd1;
                     wm400_in = inc_m400;
                  end
               end else begin
                  wm_in = wm_ff + 4'd1;
               end
            end else if (act_ff == ACT_SUB && wd_ff < signed'(DW'(1))) begin
               if (wrap_dn && wy_ff == '0) begin
                  werr_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  wm_in    = prev_m;
                  wm400_in = prev_m400;
                  wd_in    = wd_ff + len_prev_s;
                  if (wrap_dn) begin
                     wy_in = wy_ff - 14'd1;
                  end
               end
            end else begin
               state_in     = ST_DONE;
               cur_day_in   = wd_ff[DayBits-1:0];
               cur_month_in = wm_ff;
               cur_year_in  = wy_ff;
               cur_m400_in  = wm400_ff;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = cur_day_ff;
               rsp_month_in = cur_month_ff;
               rsp_year_in  = cur_year_ff;
               rsp_err_in   = werr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_day_ff   <= DayFirst;
         cur_month_ff <= MonthJan;
         cur_year_ff  <= BaseYear;
         cur_m400_ff  <= BaseYearMod;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cur_m400_ff  <= cur_m400_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      wd_ff        <= wd_in;
      wm_ff        <= wm_in;
      wy_ff        <= wy_in;
      wm400_ff     <= wm400_in;
      wrem_ff      <= wrem_in;
      ld_day_ff    <= ld_day_in;
      werr_ff      <= werr_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_day   = rsp_day_ff;
   assign rsp_chan.out_month = rsp_month_ff;
   assign rsp_chan.out_year  = rsp_year_ff;
   assign rsp_chan.error     = rsp_err_ff;

endmodule

>>> rtl/cdda_checker.sv
// port-level checks of the date day adder, bound to the top level
module cdda_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cdda_pkg::DayBits-1:0]   out_day,
   input logic [cdda_pkg::MonthBits-1:0] out_month,
   input logic [cdda_pkg::YearBits-1:0]  out_year
);
   import cdda_pkg::*;

   // busy after an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_month >= MonthJan) && (out_month <= MonthDec)
                    && (out_day >= DayFirst) && (out_year <= MaxYear))
      else $error("response date out of range");

   a_feb_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_month == MonthFeb) |-> (out_day <= 5'd29))
      else $error("february day too large");

endmodule

bind calendar_date_day_adder_unit cdda_checker u_cdda_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_day   (rsp_chan.out_day),
   .out_month (rsp_chan.out_month),
   .out_year  (rsp_chan.out_year)
);
